>>> rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DLR_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DLR_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dlr_pkg.sv
package dlr_pkg;

  localparam int PIX_W     = 13;
  localparam int COLOR_W   = 4;
  localparam int ORIGIN_W  = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;

  localparam logic [ORIGIN_W-1:0] ORIGIN_X_RESET = 11'd320;
  localparam logic [ORIGIN_W-1:0] ORIGIN_Y_RESET = 11'd240;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  typedef enum logic {
    BK_RUN,
    BK_DIV
  } bk_state_t;

  typedef struct packed {
    logic [ORIGIN_W-1:0] x;
    logic [ORIGIN_W-1:0] y;
  } origin_t;

  typedef struct packed {
    logic dividing;
    logic pop;
  } bk_stat_t;

endpackage

>>> rtl/dlr_ifs.sv
interface dlr_line_if #(parameter int COORD_BITS = 12);
  import dlr_pkg::*;
  logic                         valid;
  logic                         ready;
  kind_t                        kind;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;
  logic [COLOR_W-1:0]           color;

  modport source(output valid, kind, x_start, y_start, x_end, y_end, color, input ready);
  modport sink(input valid, kind, x_start, y_start, x_end, y_end, color, output ready);
endinterface

interface dlr_pix_if;
  import dlr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel_x;
  logic signed [PIX_W-1:0] pixel_y;
  logic [COLOR_W-1:0]      pixel_color;
  logic                    last;

  modport source(output valid, pixel_x, pixel_y, pixel_color, last, input ready);
  modport sink(input valid, pixel_x, pixel_y, pixel_color, last, output ready);
endinterface

>>> rtl/dlr_front.sv
// Classifies incoming items and precomputes deltas and line length.
module dlr_front #(
  parameter int COORD_BITS = 12
) (
  dlr_line_if.sink                cmd,
  input  logic                    full,
  output logic                    push,
  output logic [5*COORD_BITS+6:0] entry
);
  import dlr_pkg::*;

  localparam int C = COORD_BITS;

  typedef struct packed {
    kind_t                kind;
    logic signed [C-1:0]  xs;
    logic signed [C-1:0]  ys;
    logic                 neg_x;
    logic                 neg_y;
    logic [C-1:0]         adx;
    logic [C-1:0]         ady;
    logic [C-1:0]         len;
    logic [COLOR_W-1:0]   color;
  } entry_t;

  logic signed [C:0] dx;
  logic signed [C:0] dy;
  logic [C-1:0]      adx;
  logic [C-1:0]      ady;
  entry_t            e;

  assign dx  = $signed({cmd.x_end[C-1], cmd.x_end}) - $signed({cmd.x_start[C-1], cmd.x_start});
  assign dy  = $signed({cmd.y_end[C-1], cmd.y_end}) - $signed({cmd.y_start[C-1], cmd.y_start});
  assign adx = dx[C] ? C'(-dx) : C'(dx);
  assign ady = dy[C] ? C'(-dy) : C'(dy);

  always_comb begin
    e.kind  = cmd.kind;
    e.xs    = cmd.x_start;
    e.ys    = cmd.y_start;
    e.neg_x = dx[C];
    e.neg_y = dy[C];
    e.adx   = adx;
    e.ady   = ady;
    e.len   = (adx >= ady) ? adx : ady;
    e.color = cmd.color;
  end

  assign entry     = e;
  assign cmd.ready = !full;
  assign push      = cmd.valid && !full;

endmodule

>>> rtl/dlr_queue.sv
// Small FIFO of classified items.
module dlr_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [DATA_W-1:0]            wdata,
  output logic                         full,
  input  logic                         pop,
  output logic [DATA_W-1:0]            rdata,
  output logic                         valid,
  output logic [$clog2(DEPTH+1)-1:0]   level
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH+1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic              do_push;
  logic              do_pop;

  assign full    = (level == LW'(DEPTH));
  assign valid   = (level != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        level <= level + LW'(1);
      end else if (do_pop && !do_push) begin
        level <= level - LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

>>> rtl/dlr_back.sv
// Executes queued items: step division on load, one pixel per tick while a line is active.
module dlr_back #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [5*COORD_BITS+6:0] entry,
  input  logic                    q_valid,
  input  dlr_pkg::origin_t        origin,
  output dlr_pkg::bk_stat_t       stat,
  dlr_pix_if.source               pix
);
  import dlr_pkg::*;

  localparam int C     = COORD_BITS;
  localparam int F     = FRAC_BITS;
  localparam int ACC_W = C + F + 2;
  localparam int STP_W = F + 2;
  localparam int CNT_W = $clog2(F+1);
  localparam logic [F-1:0] HALF = F'(1) << (F-1);

  typedef struct packed {
    kind_t                kind;
    logic signed [C-1:0]  xs;
    logic signed [C-1:0]  ys;
    logic                 neg_x;
    logic                 neg_y;
    logic [C-1:0]         adx;
    logic [C-1:0]         ady;
    logic [C-1:0]         len;
    logic [COLOR_W-1:0]   color;
  } entry_t;

  entry_t e;
  assign e = entry;

  bk_state_t state, state_next;
  logic      pop;
  logic      emit;
  logic      out_free;
  logic      last_iter;

  logic [CNT_W-1:0]        cnt;
  logic [C:0]              rem_x, rem_y;
  logic [F:0]              quo_x, quo_y;
  logic                    neg_x, neg_y;
  logic [C-1:0]            div_len;
  logic signed [ACC_W-1:0] acc_x, acc_y;
  logic signed [STP_W-1:0] step_x, step_y;
  logic [C:0]              steps_left;
  logic [COLOR_W-1:0]      line_color;
  logic                    active;

  logic                    out_valid;
  logic [PIX_W-1:0]        out_x, out_y;
  logic [COLOR_W-1:0]      out_color;
  logic                    out_last;

  // divider datapath, both axes side by side
  logic [C:0]              t_x, t_y;
  logic                    ge_x, ge_y;
  logic [F:0]              qx_fin, qy_fin;
  logic signed [STP_W-1:0] sx_fin, sy_fin;

  always_comb begin
    t_x    = (cnt == '0) ? rem_x : {rem_x[C-1:0], 1'b0};
    t_y    = (cnt == '0) ? rem_y : {rem_y[C-1:0], 1'b0};
    ge_x   = (t_x >= {1'b0, div_len});
    ge_y   = (t_y >= {1'b0, div_len});
    qx_fin = {quo_x[F-1:0], ge_x};
    qy_fin = {quo_y[F-1:0], ge_y};
    if (div_len == '0) begin
      sx_fin = '0;
      sy_fin = '0;
    end else begin
      sx_fin = neg_x ? -$signed({1'b0, qx_fin}) : $signed({1'b0, qx_fin});
      sy_fin = neg_y ? -$signed({1'b0, qy_fin}) : $signed({1'b0, qy_fin});
    end
  end

  // pixel rounding: halves go toward zero of k*step
  logic [F-1:0]            frac_x, frac_y;
  logic signed [C+1:0]     int_x, int_y;
  logic                    up_x, up_y;
  logic signed [C+1:0]     px, py;
  logic [PIX_W-1:0]        px13, py13;

  always_comb begin
    frac_x = acc_x[F-1:0];
    frac_y = acc_y[F-1:0];
    int_x  = acc_x[ACC_W-1:F];
    int_y  = acc_y[ACC_W-1:F];
    up_x   = (frac_x > HALF) || ((frac_x == HALF) && step_x[STP_W-1]);
    up_y   = (frac_y > HALF) || ((frac_y == HALF) && step_y[STP_W-1]);
    px     = int_x + $signed({{(C+1){1'b0}}, up_x});
    py     = int_y + $signed({{(C+1){1'b0}}, up_y});
    px13   = PIX_W'(px);
    py13   = PIX_W'(py);
  end

  assign out_free  = !out_valid || pix.ready;
  assign last_iter = (cnt == CNT_W'(F));

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    emit       = 1'b0;
    unique case (state)
      BK_RUN: begin
        if (q_valid) begin
          if (e.kind == KIND_LOAD) begin
            pop        = 1'b1;
            state_next = BK_DIV;
          end else if (!active) begin
            pop = 1'b1;
          end else if (out_free) begin
            pop  = 1'b1;
            emit = 1'b1;
          end
        end
      end
      BK_DIV: begin
        if (last_iter) begin
          state_next = BK_RUN;
        end
      end
      default: state_next = BK_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_RUN;
      active    <= 1'b0;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      state <= state_next;
      if (pop && (e.kind == KIND_LOAD)) begin
        active <= 1'b0;
        cnt    <= '0;
      end else if (state == BK_DIV) begin
        cnt <= cnt + CNT_W'(1);
        if (last_iter) begin
          active <= 1'b1;
        end
      end else if (emit && (steps_left == (C+1)'(1))) begin
        active <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pix.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (e.kind == KIND_LOAD)) begin
      acc_x      <= $signed({{2{e.xs[C-1]}}, e.xs, {F{1'b0}}});
      acc_y      <= $signed({{2{e.ys[C-1]}}, e.ys, {F{1'b0}}});
      rem_x      <= {1'b0, e.adx};
      rem_y      <= {1'b0, e.ady};
      neg_x      <= e.neg_x;
      neg_y      <= e.neg_y;
      div_len    <= e.len;
      line_color <= e.color;
    end else if (state == BK_DIV) begin
      rem_x <= ge_x ? t_x - {1'b0, div_len} : t_x;
      rem_y <= ge_y ? t_y - {1'b0, div_len} : t_y;
      quo_x <= qx_fin;
      quo_y <= qy_fin;
      if (last_iter) begin
        step_x     <= sx_fin;
        step_y     <= sy_fin;
        steps_left <= (C+1)'(div_len) + (C+1)'(1);
      end
    end else if (emit) begin
      acc_x      <= acc_x + ACC_W'(step_x);
      acc_y      <= acc_y + ACC_W'(step_y);
      steps_left <= steps_left - (C+1)'(1);
    end
    if (emit) begin
      out_x     <= {2'b00, origin.x} + px13;
      out_y     <= {2'b00, origin.y} - py13;
      out_color <= line_color;
      out_last  <= (steps_left == (C+1)'(1));
    end
  end

  assign pix.valid       = out_valid;
  assign pix.pixel_x     = out_x;
  assign pix.pixel_y     = out_y;
  assign pix.pixel_color = out_color;
  assign pix.last        = out_last;

  assign stat.dividing = (state == BK_DIV);
  assign stat.pop      = pop;

endmodule

>>> rtl/dda_line_rasterizer.sv
// DDA line rasterizer.
// cmd channel (valid/ready): kind = load carries both endpoints and a color
//   and replaces any active line; kind = tick asks for the next pixel.
// pix channel (valid/ready): screen x/y, color, and last on the final pixel.
// Config port: cfg_we/cfg_index/cfg_wdata writes origin_x (0) or origin_y (1);
//   write only while the block is idle.
// After acceptance, a tick's pixel passes through its queue slot, then the
//   output register. A load runs through the radix-2 step dividers (one
//   per axis, side by side); queued ticks wait behind it.
// Throughput: one pixel per cycle while ticks stream and pix is ready; a
//   new load is not taken until the last one has finished its division.
// cmd.ready drops only when the 4-entry command queue is full.
// A stalled pix receiver holds the output register; the back end stops
//   popping ticks for the active line but the front keeps filling the queue.
// Reset: synchronous; origins return to 320/240, no line is active and
//   ticks before the first load produce nothing.
`include "assert_macros.svh"

module dda_line_rasterizer #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dlr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dlr_pkg::ORIGIN_W-1:0]    cfg_wdata,
  dlr_line_if.sink                        cmd,
  dlr_pix_if.source                       pix
);
  import dlr_pkg::*;

  localparam int ENTRY_W = 5*COORD_BITS + 7;
  localparam int LEVEL_W = $clog2(QUEUE_DEPTH+1);

  origin_t              origin;
  bk_stat_t             bk_stat;
  logic                 q_push;
  logic                 q_full;
  logic                 q_valid;
  logic [ENTRY_W-1:0]   q_wdata;
  logic [ENTRY_W-1:0]   q_rdata;
  logic [LEVEL_W-1:0]   q_level;

  // origin registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      origin.x <= ORIGIN_X_RESET;
      origin.y <= ORIGIN_Y_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORIGIN_X: origin.x <= cfg_wdata;
        CFG_ORIGIN_Y: origin.y <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // front: accept and classify
  dlr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .cmd  (cmd),
    .full (q_full),
    .push (q_push),
    .entry(q_wdata)
  );

  // decoupling queue
  dlr_queue #(
    .DATA_W(ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (bk_stat.pop),
    .rdata(q_rdata),
    .valid(q_valid),
    .level(q_level)
  );

  // back: divider, accumulators, output register
  dlr_back #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .entry  (q_rdata),
    .q_valid(q_valid),
    .origin (origin),
    .stat   (bk_stat),
    .pix    (pix)
  );

  `DLR_ASSERT_IMP(a_level_bound, clk, rst, 1'b1, q_level <= LEVEL_W'(QUEUE_DEPTH), "queue over depth")
  `DLR_ASSERT_IMP(a_no_pop_in_div, clk, rst, bk_stat.dividing, !bk_stat.pop, "pop during division")
  `DLR_ASSERT_IMP(a_no_pop_empty, clk, rst, q_level == '0, !bk_stat.pop, "pop from empty queue")
  `DLR_ASSERT_NEXT(a_reset_idle, clk, 1'b0, rst, !pix.valid && !bk_stat.dividing, "busy after reset")

endmodule
